// ----- design/ftrc_pkg.sv -----
// ----------------------------------------------------------------------------
// ftrc_pkg
// Shared constants and types of the FIFO result cache with time-to-live.
// ----------------------------------------------------------------------------
package ftrc_pkg;

  localparam int unsigned CapacityDefault = 1024;
  localparam int unsigned KeyW = 32;
  localparam int unsigned TimeW = 32;

  // Operation codes.
  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;

  // Status codes.
  localparam logic [1:0] StMiss    = 2'd0;
  localparam logic [1:0] StExpired = 2'd1;
  localparam logic [1:0] StHit     = 2'd2;
  localparam logic [1:0] StDone    = 2'd3;

  // One stored entry: value bit, deadline, key from the lowest bit up.
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] deadline;
    logic             value;
  } entry_t;

endpackage

// ----- design/ftrc_store.sv -----
// ----------------------------------------------------------------------------
// ftrc_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ftrc_store
  import ftrc_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault,
  parameter int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [CAPACITY];

  // Registered read; a read of the address being written returns the old entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/fifo_ttl_result_cache_unit.sv -----
// ----------------------------------------------------------------------------
// fifo_ttl_result_cache_unit
// FIFO-ordered cache of one-bit results with a deadline per entry.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and in_tready is low while it is worked.
// All work goes through one single-port-read entry memory driven by a small
// sequencer; every memory read is requested in one state and its registered
// data is used in the following state. An insert appends the new entry when
// there is room; when the list is full the oldest entry is removed first by
// shifting all later entries down one place. A lookup scans from the oldest
// entry up to the match or the end of the list, and goes straight to the
// result on an empty list. A remove scans the same way and then shifts
// every entry behind the match down one place. The result sits in an
// output register that also serves as the working status, so the next input
// is taken only once the previous result has left or leaves in that same
// cycle; after a result is raised the sequencer returns to S_IDLE before the
// next accept.
module fifo_ttl_result_cache_unit
  import ftrc_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  // Fields from bit 0: op[1:0], key_hash[33:2], now[65:34], ttl[97:66],
  // value_bit[98], zero fill to 104 bits.
  input  logic [103:0] in_tdata,
  output logic       out_tvalid,
  input  logic       out_tready,
  // Fields from bit 0: status[1:0], hit_value[2], zero fill to 8 bits.
  output logic [7:0] out_tdata
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CHECK, S_SHIFT_RD, S_SHIFT_WR, S_APPEND, S_RESULT
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     idx_r;
  logic [1:0]        op_r;
  logic [KeyW-1:0]   key_r;
  logic [TimeW-1:0]  now_r;
  logic [TimeW-1:0]  dl_r;
  logic              vbit_r;
  logic [1:0]        status_r;
  logic              hv_r;
  logic              ovalid_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_data;
  logic [TimeW:0]    dl_sum;
  logic              out_free;

  assign dl_sum = {1'b0, in_tdata[65:34]} + {1'b0, in_tdata[97:66]};
  assign out_free = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign out_tvalid = ovalid_r;
  assign out_tdata = {5'd0, hv_r, status_r};

  // Memory control: read at the scan index, write shifted or appended entries.
  always_comb begin
    rd_addr = idx_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = rd_data;
    if (state_r == S_SHIFT_WR) begin
      wr_en   = 1'b1;
      wr_addr = AW'(idx_r - CW'(1));
    end else if (state_r == S_APPEND) begin
      wr_en   = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = '{key: key_r, deadline: dl_r, value: vbit_r};
    end
  end

  ftrc_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
      status_r <= StMiss;
      hv_r     <= 1'b0;
    end else begin
      // A new result replaces the one that leaves in the same cycle.
      if (state_r == S_RESULT && out_free) begin
        ovalid_r <= 1'b1;
      end else if (ovalid_r && out_tready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r   <= in_tdata[1:0];
            key_r  <= in_tdata[33:2];
            now_r  <= in_tdata[65:34];
            dl_r   <= dl_sum[TimeW] ? '1 : dl_sum[TimeW-1:0];
            vbit_r <= in_tdata[98];
            idx_r  <= '0;
            hv_r   <= 1'b0;
            case (in_tdata[1:0])
              OpInsert: begin
                status_r <= StDone;
                if (count_r == CapC) begin
                  idx_r   <= CW'(1);
                  state_r <= S_SHIFT_RD;
                end else begin
                  state_r <= S_APPEND;
                end
              end
              OpLookup: begin
                status_r <= StMiss;
                state_r  <= (count_r == '0) ? S_RESULT : S_SCAN;
              end
              OpRemove: begin
                status_r <= StDone;
                state_r  <= (count_r == '0) ? S_RESULT : S_SCAN;
              end
              default: begin
                status_r <= StMiss;
                state_r  <= S_RESULT;
              end
            endcase
          end
        end
        // Read data for idx_r arrives next cycle.
        S_SCAN: state_r <= S_CHECK;
        S_CHECK: begin
          if (rd_data.key == key_r) begin
            if (op_r == OpLookup) begin
              if (rd_data.deadline < now_r) begin
                status_r <= StExpired;
              end else begin
                status_r <= StHit;
                hv_r     <= rd_data.value;
              end
              state_r <= S_RESULT;
            end else begin
              idx_r   <= idx_r + CW'(1);
              state_r <= S_SHIFT_RD;
            end
          end else if (idx_r + CW'(1) >= count_r) begin
            state_r <= S_RESULT;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_SCAN;
          end
        end
        // Move entries behind the gap down by one place.
        S_SHIFT_RD: begin
          if (idx_r >= count_r) begin
            count_r <= count_r - CW'(1);
            state_r <= (op_r == OpInsert) ? S_APPEND : S_RESULT;
          end else begin
            state_r <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx_r   <= idx_r + CW'(1);
          state_r <= S_SHIFT_RD;
        end
        S_APPEND: begin
          count_r <= count_r + CW'(1);
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CapC) else $error("entry count above capacity");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready while busy");
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPEND |-> count_r < CapC) else $error("append on full list");
  a_hit_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status_r != StHit |-> !hv_r) else $error("hit value without hit");

endmodule
